### sv/gpoll_pkg.sv
// Package: shared types, constants and decode helpers for the gamepad poll master.
package gpoll_pkg;

    // Bytes of a frame that the report ever looks at (bytes zero to eight).
    localparam int REPORT_BYTES = 9;

    localparam logic [7:0]  CMD_START     = 8'h01;
    localparam logic [7:0]  CMD_POLL      = 8'h42;
    localparam logic [7:0]  CMD_IDLE      = 8'h00;
    localparam logic [7:0]  ID_ANALOG     = 8'h73;
    localparam logic [15:0] HALF_PER_RST  = 16'd300;

    localparam int ID_BYTE  = 1;
    localparam int BTN_LO   = 3;
    localparam int BTN_HI   = 4;
    localparam int RX_BYTE  = 5;
    localparam int RY_BYTE  = 6;
    localparam int LX_BYTE  = 7;
    localparam int LY_BYTE  = 8;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LOW  = 2'd1,
        PH_HIGH = 2'd2
    } phase_t;

    typedef logic [REPORT_BYTES-1:0][7:0] frame_t;

    typedef struct packed {
        logic [7:0]  id_byte;
        logic        red_mode;
        logic [15:0] buttons;
        logic [4:0]  key_code;
        logic [7:0]  right_x;
        logic [7:0]  right_y;
        logic [7:0]  left_x;
        logic [7:0]  left_y;
    } report_t;

    // Lowest cleared bit index plus one; zero when every bit is set.
    function automatic logic [4:0] key_of(input logic [15:0] btn);
        logic [4:0] key;
        key = 5'd0;
        for (int i = 15; i >= 0; i--) begin
            if (!btn[i]) begin
                key = 5'(i + 1);
            end
        end
        return key;
    endfunction

endpackage

### sv/gpoll_if.sv
// Interfaces: tick channel in and pin/report channel out.
interface gpoll_in_if;
    logic valid;
    logic ready;
    logic action;
    logic data_in;

    modport source (output valid, output action, output data_in, input ready);
    modport sink   (input valid, input action, input data_in, output ready);
endinterface

interface gpoll_out_if;
    logic        valid;
    logic        ready;
    logic        clk_level;
    logic        select_level;
    logic        cmd_level;
    logic        frame_done;
    logic [7:0]  id_byte;
    logic        red_mode;
    logic [15:0] buttons;
    logic [4:0]  key_code;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
    logic [7:0]  left_x;
    logic [7:0]  left_y;

    modport source (
        output valid, output clk_level, output select_level, output cmd_level,
        output frame_done, output id_byte, output red_mode, output buttons,
        output key_code, output right_x, output right_y, output left_x,
        output left_y, input ready
    );
    modport sink (
        input valid, input clk_level, input select_level, input cmd_level,
        input frame_done, input id_byte, input red_mode, input buttons,
        input key_code, input right_x, input right_y, input left_x,
        input left_y, output ready
    );
endinterface

### sv/gamepad_serial_poll_master.sv
// Top level: gamepad poll master, serial engine stepped one tick per word.
//
//  channel   | dir | handshake      | payload
//  ----------+-----+----------------+------------------------------------------
//  in_ch     | in  | valid/ready    | action, data_in (one tick or a start)
//  out_ch    | out | valid/ready    | pin levels, frame_done, decoded report
//  cfg       | in  | cfg_we         | cfg_wdata = half_period (16 bit)
//
//  One word in gives one word out, in the cycle after it is accepted; a new word is
//  taken every cycle unless stalled. The serial state and the output register both load
//  on the accepting edge, so the output word is held in that single output register.
//  Reset clears the engine to idle (select high, clock high), half_period 300.
//  in_ch.ready drops only when the output register is full and out_ch.ready
//  is low; the engine does not advance while stalled.
//
//  Bits go LSB first: half_period ticks with clock low, half_period ticks with
//  clock high; the data line is sampled on the tick the clock rises. Commands
//  0x01 then 0x42, command line low for the remaining bytes. A start word
//  restarts the frame at once; a half_period of zero behaves as one.
module gamepad_serial_poll_master #(
    parameter int FRAME_BYTES = 9
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    gpoll_in_if.sink    in_ch,
    gpoll_out_if.source out_ch
);
    import gpoll_pkg::*;

    localparam int CW = $clog2(FRAME_BYTES);

    // configuration
    logic [15:0] half_period_reg;
    logic [15:0] hp;

    // serial engine state
    phase_t          phase_reg, phase_next;
    logic [CW-1:0]   byte_count_reg, byte_count_next;
    logic [2:0]      bit_count_reg, bit_count_next;
    logic [15:0]     tick_count_reg, tick_count_next;
    logic [7:0]      shift_reg, shift_next;
    frame_t          frame_reg, frame_next;

    logic            accept;
    logic            done;
    logic            sample;
    logic [15:0]     tick_inc;
    logic [CW-1:0]   byte_inc;

    // output word
    logic            out_valid_reg;
    logic            clk_lvl_next, sel_lvl_next, cmd_lvl_next;
    logic            clk_lvl_reg, sel_lvl_reg, cmd_lvl_reg, done_reg;
    report_t         report;
    report_t         report_reg;

    assign hp       = (half_period_reg == 16'd0) ? 16'd1 : half_period_reg;
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept   = in_ch.valid && in_ch.ready;
    assign tick_inc = tick_count_reg + 16'd1;
    assign byte_inc = byte_count_reg + CW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PER_RST;
        end
        else if (cfg_we)
        begin
            half_period_reg <= cfg_wdata;
        end
    end

    // next state of the serial engine
    always_comb
    begin
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        bit_count_next  = bit_count_reg;
        tick_count_next = tick_count_reg;
        shift_next      = shift_reg;
        frame_next      = frame_reg;
        done            = 1'b0;
        sample          = 1'b0;

        if (accept)
        begin
            if (in_ch.action)
            begin
                frame_next      = '0;
                byte_count_next = '0;
                bit_count_next  = '0;
                tick_count_next = '0;
                phase_next      = PH_LOW;
                shift_next      = CMD_START;
            end
            else
            begin
                case (phase_reg)
                    PH_LOW:
                    begin
                        tick_count_next = tick_inc;
                        if (tick_inc >= hp)
                        begin
                            sample          = 1'b1;
                            phase_next      = PH_HIGH;
                            tick_count_next = '0;
                        end
                    end
                    PH_HIGH:
                    begin
                        tick_count_next = tick_inc;
                        if (tick_inc >= hp)
                        begin
                            tick_count_next = '0;
                            if (bit_count_reg == 3'd7)
                            begin
                                bit_count_next = '0;
                                if (byte_count_reg == CW'(FRAME_BYTES - 1))
                                begin
                                    phase_next      = PH_IDLE;
                                    byte_count_next = '0;
                                    shift_next      = '0;
                                    done            = 1'b1;
                                end
                                else
                                begin
                                    byte_count_next = byte_inc;
                                    shift_next      = (byte_inc == CW'(1)) ? CMD_POLL
                                                                           : CMD_IDLE;
                                    phase_next      = PH_LOW;
                                end
                            end
                            else
                            begin
                                bit_count_next = bit_count_reg + 3'd1;
                                shift_next     = shift_reg >> 1;
                                phase_next     = PH_LOW;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end

            // reply of byte zero is dropped; bytes past the report are not kept
            for (int j = 1; j < REPORT_BYTES; j++)
            begin
                if (sample && in_ch.data_in && (int'(byte_count_reg) == j))
                begin
                    frame_next[j][bit_count_reg] = 1'b1;
                end
            end
        end
    end

    // pin levels follow the state after this tick
    always_comb
    begin
        clk_lvl_next = (phase_next != PH_LOW);
        sel_lvl_next = (phase_next == PH_IDLE);
        cmd_lvl_next = (phase_next == PH_IDLE) ? 1'b0 : shift_next[0];
    end

    gpoll_report u_report (
        .frame  (frame_reg),
        .done   (done),
        .report (report)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            byte_count_reg <= '0;
            bit_count_reg  <= '0;
            tick_count_reg <= '0;
            shift_reg      <= '0;
            frame_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            bit_count_reg  <= bit_count_next;
            tick_count_reg <= tick_count_next;
            shift_reg      <= shift_next;
            frame_reg      <= frame_next;
            out_valid_reg  <= accept || (out_valid_reg && !out_ch.ready);
        end
    end

    // output word register, loads with each accepted tick
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            clk_lvl_reg <= clk_lvl_next;
            sel_lvl_reg <= sel_lvl_next;
            cmd_lvl_reg <= cmd_lvl_next;
            done_reg    <= done;
            report_reg  <= report;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.clk_level    = clk_lvl_reg;
    assign out_ch.select_level = sel_lvl_reg;
    assign out_ch.cmd_level    = cmd_lvl_reg;
    assign out_ch.frame_done   = done_reg;
    assign out_ch.id_byte      = report_reg.id_byte;
    assign out_ch.red_mode     = report_reg.red_mode;
    assign out_ch.buttons      = report_reg.buttons;
    assign out_ch.key_code     = report_reg.key_code;
    assign out_ch.right_x      = report_reg.right_x;
    assign out_ch.right_y      = report_reg.right_y;
    assign out_ch.left_x       = report_reg.left_x;
    assign out_ch.left_y       = report_reg.left_y;

endmodule

### sv/gpoll_report.sv
// Frame decode: picks the report fields out of the frame store.
module gpoll_report (
    input  gpoll_pkg::frame_t  frame,
    input  logic               done,
    output gpoll_pkg::report_t report
);
    import gpoll_pkg::*;

    logic [15:0] btn;

    assign btn = {frame[BTN_HI], frame[BTN_LO]};

    always_comb
    begin
        report = '0;
        if (done)
        begin
            report.id_byte  = frame[ID_BYTE];
            report.red_mode = (frame[ID_BYTE] == ID_ANALOG);
            report.buttons  = btn;
            report.key_code = key_of(btn);
            report.right_x  = frame[RX_BYTE];
            report.right_y  = frame[RY_BYTE];
            report.left_x   = frame[LX_BYTE];
            report.left_y   = frame[LY_BYTE];
        end
    end

endmodule

### dv/tb_top.sv
// Self-checking testbench for the gamepad serial poll master (tick stream in, pin/report out).
`timescale 1ns / 100ps

module tb_top;
    import gpoll_pkg::*;

    localparam int FRAME_LEN   = 9;
    localparam int WORD_TARGET = 850;

    // Pin levels plus the decoded report, exactly as one output word carries them
    typedef struct packed {
        logic    clk_level;
        logic    select_level;
        logic    cmd_level;
        logic    frame_done;
        report_t rpt;
    } pin_word_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    gpoll_in_if  in_ch ();
    gpoll_out_if out_ch ();

    gamepad_serial_poll_master #(
        .FRAME_BYTES (FRAME_LEN)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Engine predictor: own copy of the serial state and of half_period
    // ------------------------------------------------------------------
    logic [15:0] half_per  = HALF_PER_RST;
    logic [7:0]  rx_bytes [FRAME_LEN] = '{default: 8'h00};
    logic [3:0]  byte_cnt  = '0;
    logic [2:0]  bit_cnt   = '0;
    logic [15:0] tick_cnt  = '0;
    phase_t      eng_phase = PH_IDLE;
    logic [7:0]  cmd_shift = '0;

    // Bytes the emulated gamepad answers with during the current frame
    logic [7:0]  pad_bytes [FRAME_LEN];

    pin_word_t   pending_words [$];

    int n_words    = 0;
    int n_frames   = 0;
    int n_red      = 0;
    int n_restarts = 0;
    int n_fail     = 0;
    bit in_calm    = 1'b0;

    // A written zero behaves as one
    function automatic logic [15:0] eff_half();
        return (half_per == 16'd0) ? 16'd1 : half_per;
    endfunction

    // Report bytes past the end of the frame read as zero
    function automatic logic [7:0] byte_at(int k);
        return (k < FRAME_LEN) ? rx_bytes[k] : 8'h00;
    endfunction

    // Advance the predicted engine by one accepted word and build the expected output word
    function automatic void step_engine(input logic act, input logic din, output pin_word_t w);
        logic [15:0] hp;
        logic [15:0] btn;
        logic [4:0]  key;
        bit          found;
        bit          done;
        hp   = eff_half();
        done = 1'b0;
        if (act) begin
            // start: abandons any running frame
            foreach (rx_bytes[i]) rx_bytes[i] = 8'h00;
            byte_cnt  = '0;
            bit_cnt   = '0;
            tick_cnt  = '0;
            eng_phase = PH_LOW;
            cmd_shift = CMD_START;
        end
        else if (eng_phase == PH_LOW) begin
            tick_cnt = tick_cnt + 16'd1;
            if (tick_cnt >= hp) begin
                // rising clock: sample, but the reply to byte zero is thrown away
                if (byte_cnt != 0 && byte_cnt < FRAME_LEN && din)
                    rx_bytes[byte_cnt][bit_cnt] = 1'b1;
                eng_phase = PH_HIGH;
                tick_cnt  = '0;
            end
        end
        else if (eng_phase == PH_HIGH) begin
            tick_cnt = tick_cnt + 16'd1;
            if (tick_cnt >= hp) begin
                tick_cnt = '0;
                if (bit_cnt == 3'd7) begin
                    bit_cnt  = '0;
                    byte_cnt = byte_cnt + 4'd1;
                    if (byte_cnt >= FRAME_LEN) begin
                        eng_phase = PH_IDLE;
                        byte_cnt  = '0;
                        cmd_shift = '0;
                        done      = 1'b1;
                    end
                    else begin
                        cmd_shift = (byte_cnt == 4'd1) ? CMD_POLL : CMD_IDLE;
                        eng_phase = PH_LOW;
                    end
                end
                else begin
                    bit_cnt   = bit_cnt + 3'd1;
                    cmd_shift = cmd_shift >> 1;
                    eng_phase = PH_LOW;
                end
            end
        end
        else begin
            eng_phase = PH_IDLE;
        end

        w              = '0;
        w.clk_level    = (eng_phase != PH_LOW);
        w.select_level = (eng_phase == PH_IDLE);
        w.cmd_level    = (eng_phase == PH_IDLE) ? 1'b0 : cmd_shift[0];
        w.frame_done   = done;
        if (done) begin
            btn   = {byte_at(BTN_HI), byte_at(BTN_LO)};
            key   = 5'd0;
            found = 1'b0;
            for (int i = 0; i < 16; i++) begin
                if (!found && !btn[i]) begin
                    key   = 5'(i + 1);
                    found = 1'b1;
                end
            end
            w.rpt.id_byte  = byte_at(ID_BYTE);
            w.rpt.red_mode = (byte_at(ID_BYTE) == ID_ANALOG);
            w.rpt.buttons  = btn;
            w.rpt.key_code = key;
            w.rpt.right_x  = byte_at(RX_BYTE);
            w.rpt.right_y  = byte_at(RY_BYTE);
            w.rpt.left_x   = byte_at(LX_BYTE);
            w.rpt.left_y   = byte_at(LY_BYTE);
        end
    endfunction

    // Data line level for the next tick: the pad's bit on a sampling tick, noise otherwise
    function automatic logic next_din();
        if (eng_phase == PH_LOW && 16'(tick_cnt + 16'd1) >= eff_half())
            return pad_bytes[byte_cnt][bit_cnt];
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void fill_pad(input logic [7:0] b0, input logic [7:0] id,
                                     input logic [15:0] btn, input logic [7:0] rx,
                                     input logic [7:0] ry, input logic [7:0] lx,
                                     input logic [7:0] ly);
        pad_bytes[0]       = b0;
        pad_bytes[ID_BYTE] = id;
        pad_bytes[2]       = rand_byte();
        pad_bytes[BTN_LO]  = btn[7:0];
        pad_bytes[BTN_HI]  = btn[15:8];
        pad_bytes[RX_BYTE] = rx;
        pad_bytes[RY_BYTE] = ry;
        pad_bytes[LX_BYTE] = lx;
        pad_bytes[LY_BYTE] = ly;
    endfunction

    // Sender gap: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (in_calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // ------------------------------------------------------------------
    // Sending side
    // ------------------------------------------------------------------

    // Offer one word and wait for the handshake; returns at the accepting edge
    task automatic send_word(input logic act, input logic din);
        int        gap;
        pin_word_t w;
        @(negedge clk);
        gap = pick_gap();
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.action  <= act;
        in_ch.data_in <= din;
        do @(posedge clk); while (!in_ch.ready);
        step_engine(act, din, w);
        pending_words.push_back(w);
        n_words++;
        if (w.frame_done) begin
            n_frames++;
            if (w.rpt.red_mode) n_red++;
        end
    endtask

    // Stop offering words and hold off until every expected word is back
    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_words.size() != 0) @(negedge clk);
    endtask

    // Register writes only ever happen with nothing in flight
    task automatic write_half_period(input logic [15:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        half_per  = v;
    endtask

    // One poll frame from start to report, optionally restarted part way through
    task automatic run_frame(input bit may_abort);
        int abort_at;
        int k;
        abort_at = (may_abort && $urandom_range(0, 4) == 0) ? $urandom_range(0, 150) : -1;
        in_calm  = ($urandom_range(0, 3) == 0);
        send_word(1'b1, 1'($urandom_range(0, 1)));
        k = 0;
        while (eng_phase != PH_IDLE) begin
            if (k == abort_at) begin
                n_restarts++;
                send_word(1'b1, 1'($urandom_range(0, 1)));
            end
            else begin
                send_word(1'b0, next_din());
            end
            k++;
        end
        in_calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiving side: ready toggles in stretches, some with no stalls at all
    // ------------------------------------------------------------------
    initial
    begin
        int mode;
        int run;
        out_ch.ready = 1'b0;
        forever begin
            mode = $urandom_range(0, 9);
            run  = $urandom_range(10, 80);
            repeat (run) begin
                @(negedge clk);
                if (mode < 3)
                    out_ch.ready <= 1'b1;
                else if (mode < 9)
                    out_ch.ready <= ($urandom_range(0, 3) != 0);
                else
                    out_ch.ready <= ($urandom_range(0, 19) == 0);
            end
        end
    end

    function automatic void chk_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_fail++;
        end
    endfunction

    // Output checker: every accepted word against the oldest expectation
    always @(posedge clk)
    begin : out_check
        pin_word_t e;
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
            if (pending_words.size() == 0) begin
                $error("output word with no expectation pending");
                n_fail++;
            end
            else begin
                e = pending_words.pop_front();
                chk_field("clk_level",    e.clk_level,    out_ch.clk_level);
                chk_field("select_level", e.select_level, out_ch.select_level);
                chk_field("cmd_level",    e.cmd_level,    out_ch.cmd_level);
                chk_field("frame_done",   e.frame_done,   out_ch.frame_done);
                chk_field("id_byte",      e.rpt.id_byte,  out_ch.id_byte);
                chk_field("red_mode",     e.rpt.red_mode, out_ch.red_mode);
                chk_field("buttons",      e.rpt.buttons,  out_ch.buttons);
                chk_field("key_code",     e.rpt.key_code, out_ch.key_code);
                chk_field("right_x",      e.rpt.right_x,  out_ch.right_x);
                chk_field("right_y",      e.rpt.right_y,  out_ch.right_y);
                chk_field("left_x",       e.rpt.left_x,   out_ch.left_x);
                chk_field("left_y",       e.rpt.left_y,   out_ch.left_y);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Plain ticks straight out of reset: pins must sit idle
    task automatic test_idle_after_reset();
        for (int k = 0; k < 4; k++) send_word(1'b0, 1'(k));
    endtask

    // Start at the reset half period, then restart mid-frame
    task automatic test_restart_mid_frame();
        send_word(1'b1, 1'b1);
        for (int k = 0; k < 12; k++) send_word(1'b0, 1'(k));
        n_restarts++;
        send_word(1'b1, 1'b0);
        for (int k = 0; k < 6; k++) send_word(1'b0, 1'(~k));
    endtask

    // Zero behaves as one; first frame drives ones during byte zero to check it is discarded
    task automatic test_zero_half_period();
        write_half_period(16'd0);
        fill_pad(8'hFF, ID_ANALOG, 16'hFFFF, 8'h00, 8'hFF, 8'h80, 8'h7F);
        run_frame(1'b0);
        // only bit 15 pressed gives the highest key code; sticks at the opposite extremes
        fill_pad(8'h00, 8'h41, 16'h7FFF, 8'hFF, 8'h00, 8'h7F, 8'h80);
        run_frame(1'b0);
    endtask

    // Longest half period: the clock must stay low for the whole stretch
    task automatic test_max_half_period();
        write_half_period(16'hFFFF);
        send_word(1'b1, 1'b1);
        for (int k = 0; k < 30; k++) send_word(1'b0, 1'($urandom_range(0, 1)));
        n_restarts++;
        send_word(1'b1, 1'b0);
        for (int k = 0; k < 10; k++) send_word(1'b0, 1'($urandom_range(0, 1)));
    endtask

    // Well-formed frames with random content, short half periods, some restarts and noise
    task automatic test_random_frames();
        int          r;
        logic [15:0] hp;
        logic [15:0] btn;
        logic [7:0]  id;
        while (n_words < WORD_TARGET) begin
            r  = $urandom_range(0, 9);
            hp = (r < 6) ? 16'd1 : (r < 8) ? 16'd2 : (r < 9) ? 16'd3 : 16'd0;
            if (hp != half_per) write_half_period(hp);

            r   = $urandom_range(0, 19);
            id  = (r < 10) ? ID_ANALOG : (r < 13) ? 8'h41 : rand_byte();
            r   = $urandom_range(0, 9);
            btn = (r < 4) ? 16'hFFFF
                : (r < 8) ? ~(16'h0001 << $urandom_range(0, 15))
                : 16'($urandom_range(0, 65535));
            fill_pad(rand_byte(), id, btn, rand_byte(), rand_byte(), rand_byte(), rand_byte());
            run_frame(1'b1);

            // a few stray ticks while idle between frames
            repeat ($urandom_range(0, 4)) send_word(1'b0, 1'($urandom_range(0, 1)));
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 16'd0;
        in_ch.valid   = 1'b0;
        in_ch.action  = 1'b0;
        in_ch.data_in = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        test_idle_after_reset();
        test_restart_mid_frame();
        test_zero_half_period();
        test_max_half_period();
        test_random_frames();

        drain();
        repeat (5) @(posedge clk);
        if (pending_words.size() != 0) begin
            $error("%0d expected words never arrived", pending_words.size());
            n_fail++;
        end

        $display("Run covered %0d words, %0d full frames (%0d in analogue mode), %0d restarts.",
                 n_words, n_frames, n_red, n_restarts);
        $display("Half periods exercised: reset value, 0, 1, 2, 3 and 65535.");
        if (n_fail == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
